/* sv/lpd_pkg.sv */
// Shared types and constants for the length-prefixed frame deframer.
// No dependencies; used by lpd_core, lpd_out_reg and length_prefix_deframer.
package lpd_pkg;

  localparam logic [31:0] LEN_LIMIT_RST = 32'd16777216;
  localparam logic [31:0] LEN_SAT       = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DISCARD = 2'd2,
    PH_CLOSED  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_BYTE     = 3'd0,
    EV_EMPTY    = 3'd1,
    EV_OVERSIZE = 3'd2,
    EV_TRUNC    = 3'd3,
    EV_CLOSE    = 3'd4
  } evt_kind_t;

  typedef struct packed {
    evt_kind_t   kind;
    logic [7:0]  data;
    logic        last;
  } res_t;

endpackage

/* sv/lpd_core.sv */
// Deframer state machine: prefix gathering, payload/discard counting, close.
// Holds the frame length limit register. Depends on lpd_pkg.
module lpd_core #(
  parameter int PREFIX_BYTES = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [31:0]   cfg_wr_data,
  input  logic          item_acc,
  input  logic [7:0]    item_byte,
  input  logic          item_eos,
  output logic          res_valid,
  output lpd_pkg::res_t res
);

  localparam int HCW = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1;
  localparam int PLW = (PREFIX_BYTES > 1) ? (PREFIX_BYTES - 1) * 8 : 8;
  localparam int FLW = PREFIX_BYTES * 8;
  localparam int CW  = (FLW > 32) ? FLW : 32;
  localparam logic [HCW-1:0] HC_LAST = HCW'(PREFIX_BYTES - 1);

  lpd_pkg::phase_t phase_r, phase_nxt;
  logic [HCW-1:0]  header_count_r, header_count_nxt;
  logic [PLW-1:0]  partial_length_r, partial_length_nxt;
  logic [31:0]     bytes_left_r, bytes_left_nxt;
  logic [31:0]     len_limit_r;

  logic [FLW-1:0]  full_len;
  logic            len_over;
  logic            len_zero;
  logic            hdr_done;
  logic [31:0]     left_dec;
  logic [31:0]     disc_len;

  assign full_len = FLW'({partial_length_r, item_byte});
  assign len_over = CW'(full_len) > CW'(len_limit_r);
  assign len_zero = (full_len == '0);
  assign hdr_done = (header_count_r == HC_LAST);
  assign left_dec = (bytes_left_r != 32'd0) ? bytes_left_r - 32'd1 : 32'd0;
  assign disc_len = (CW'(full_len) > CW'(lpd_pkg::LEN_SAT)) ? lpd_pkg::LEN_SAT
                                                            : 32'(full_len);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (item_acc) begin
      case (phase_r)
        lpd_pkg::PH_HEADER: begin
          if (item_eos) begin
            phase_nxt = lpd_pkg::PH_CLOSED;
          end else if (hdr_done) begin
            if (len_over) begin
              phase_nxt = lpd_pkg::PH_DISCARD;
            end else if (!len_zero) begin
              phase_nxt = lpd_pkg::PH_PAYLOAD;
            end
          end
        end
        lpd_pkg::PH_PAYLOAD, lpd_pkg::PH_DISCARD: begin
          if (item_eos) begin
            phase_nxt = lpd_pkg::PH_CLOSED;
          end else if (left_dec == 32'd0) begin
            phase_nxt = lpd_pkg::PH_HEADER;
          end
        end
        lpd_pkg::PH_CLOSED: phase_nxt = lpd_pkg::PH_CLOSED;
        default:            phase_nxt = lpd_pkg::PH_CLOSED;
      endcase
    end
  end

  // counters and result
  always_comb begin
    header_count_nxt   = header_count_r;
    partial_length_nxt = partial_length_r;
    bytes_left_nxt     = bytes_left_r;
    res_valid          = 1'b0;
    res.kind           = lpd_pkg::EV_BYTE;
    res.data           = 8'd0;
    res.last           = 1'b0;
    if (item_acc && (phase_r != lpd_pkg::PH_CLOSED)) begin
      if (item_eos) begin
        header_count_nxt   = '0;
        partial_length_nxt = '0;
        bytes_left_nxt     = 32'd0;
        res_valid          = 1'b1;
        if ((phase_r == lpd_pkg::PH_PAYLOAD) ||
            ((phase_r == lpd_pkg::PH_HEADER) && (header_count_r != '0))) begin
          res.kind = lpd_pkg::EV_TRUNC;
        end else begin
          res.kind = lpd_pkg::EV_CLOSE;
        end
      end else begin
        case (phase_r)
          lpd_pkg::PH_HEADER: begin
            if (!hdr_done) begin
              header_count_nxt   = header_count_r + 1'b1;
              partial_length_nxt = full_len[PLW-1:0];
            end else begin
              header_count_nxt   = '0;
              partial_length_nxt = '0;
              if (len_over) begin
                bytes_left_nxt = disc_len;
                res_valid      = 1'b1;
                res.kind       = lpd_pkg::EV_OVERSIZE;
              end else if (len_zero) begin
                res_valid = 1'b1;
                res.kind  = lpd_pkg::EV_EMPTY;
                res.last  = 1'b1;
              end else begin
                bytes_left_nxt = 32'(full_len);
              end
            end
          end
          lpd_pkg::PH_DISCARD: begin
            bytes_left_nxt = left_dec;
          end
          lpd_pkg::PH_PAYLOAD: begin
            bytes_left_nxt = left_dec;
            res_valid      = 1'b1;
            res.kind       = lpd_pkg::EV_BYTE;
            res.data       = item_byte;
            res.last       = (left_dec == 32'd0);
          end
          default: begin
            res_valid = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= lpd_pkg::PH_HEADER;
      header_count_r   <= '0;
      partial_length_r <= '0;
      bytes_left_r     <= 32'd0;
      len_limit_r      <= lpd_pkg::LEN_LIMIT_RST;
    end else begin
      phase_r          <= phase_nxt;
      header_count_r   <= header_count_nxt;
      partial_length_r <= partial_length_nxt;
      bytes_left_r     <= bytes_left_nxt;
      if (cfg_wr_en) begin
        len_limit_r <= cfg_wr_data;
      end
    end
  end

endmodule

/* sv/lpd_out_reg.sv */
// Result register for the deframer output stream; frees the input side
// whenever the held item is taken or the register is empty. Depends on lpd_pkg.
module lpd_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_valid,
  input  lpd_pkg::res_t res,
  output logic          take_ready,
  output logic          out_valid,
  output lpd_pkg::res_t out_res,
  input  logic          out_ready
);

  logic          valid_r;
  lpd_pkg::res_t res_r;

  assign take_ready = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_ready && res_valid) begin
      res_r <= res;
    end
  end

endmodule

/* sv/length_prefix_deframer.sv */
// Length-prefixed frame deframer, top level. Instantiates lpd_core and
// lpd_out_reg; depends on lpd_pkg.
//
// Takes one stream byte per clock (tuser high marks end of stream) and turns
// PREFIX_BYTES-byte big-endian length prefixes into frames: payload bytes go
// out one per item with tlast on the last one, a zero length gives an empty
// frame event, and a length above the length limit gives one oversize event
// and the body is dropped. End of stream gives truncated or clean close, after
// which input is swallowed until reset. Throughput is one item per clock
// while in_tready is high; a result appears in the cycle after its input
// is accepted, from a single output register. in_tready drops only while
// that register holds an item the sink has not taken. The length limit is
// written via cfg_wr_en; the user must do this only while idle (unenforced).
module length_prefix_deframer #(
  parameter int PREFIX_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] stream_byte
  input  logic        in_tuser,   // [0] end_of_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] payload_byte
  output logic [2:0]  out_tuser,  // [2:0] event_kind
  output logic        out_tlast   // frame_last
);

  logic          item_acc;
  logic          res_valid;
  lpd_pkg::res_t res;
  lpd_pkg::res_t out_res;

  assign item_acc = in_tvalid && in_tready;

  lpd_core #(
    .PREFIX_BYTES(PREFIX_BYTES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_acc    (item_acc),
    .item_byte   (in_tdata),
    .item_eos    (in_tuser),
    .res_valid   (res_valid),
    .res         (res)
  );

  lpd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .take_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_res    (out_res),
    .out_ready  (out_tready)
  );

  assign out_tdata = out_res.data;
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule
